### rtl/firrs_pkg.sv
`default_nettype none

package firrs_pkg;

    // Field widths
    localparam int SAMPLE_W   = 20;
    localparam int COEF_W     = 18;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = 48;
    localparam int MAG_W      = 32;
    localparam int SCALE_SH   = 15;
    localparam int PCM_W      = 16;
    localparam int TAPCNT_W   = 9;
    localparam int COEF_IDX_W = 8;

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_TAP_COUNT = 1'b0;
    localparam logic [TAPCNT_W-1:0]   TAP_COUNT_RESET = 9'd1;

    // Item commands
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_COEF = 1'b1;

    // Unity in accumulator units (31 fraction bits) and the 48-bit limits
    localparam logic signed [ACC_W-1:0] ONE_Q31     = 48'sh0000_8000_0000;
    localparam logic signed [ACC_W-1:0] NEG_ONE_Q31 = -48'sh0000_8000_0000;
    localparam logic signed [ACC_W-1:0] ACC_MAX     = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN     = 48'sh8000_0000_0000;

    typedef struct packed {
        logic push;
        logic coef_wr;
        logic issue;
        logic clamp;
        logic load_out;
    } firrs_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } firrs_status_t;

endpackage

`default_nettype wire

### rtl/fir_filter_ring_saturate_pcm16_core.sv
`default_nettype none

// Direct-form FIR filter over a ring of past samples, 16-bit PCM out.
//
// Request channel (req_valid/req_stall) carries one beat per command:
//   cmd = push   : sample is written into the ring and one result beat follows.
//   cmd = coef   : coef_value is written to tap coef_index; no result beat.
// Result channel (res_valid/res_stall) carries pcm and clipped. tap_count is
// set over APB at byte address 0 while the block is idle; the user must ensure
// this, as the block itself does not enforce it.
// Operation: a coefficient write goes straight to the tap table. A push runs
// one shared multiply-accumulate per tap, one tap per cycle through a
// registered tap table read, a multiplier stage and the accumulator, for
// tap_count taps (saturated to MAX_TAPS). The pipe then drains, the sum is
// clamped and scaled into the output register, and the result is valid in
// the same cycle in which the next beat can be taken.
// Reset clears the ring (through a fill count, so unwritten slots read as
// zero), the write pointer and sets tap_count to 1; coefficients must be
// loaded before samples flow. If the receiver stalls, the result is held
// in the output register and the block waits with the next result ready.
module fir_filter_ring_saturate_pcm16_core #(
    parameter int MAX_TAPS = 256
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    req_valid,
    output logic                                    req_stall,
    input  logic                                    cmd,
    input  logic signed [firrs_pkg::SAMPLE_W-1:0]   sample,
    input  logic [firrs_pkg::COEF_IDX_W-1:0]        coef_index,
    input  logic signed [firrs_pkg::COEF_W-1:0]     coef_value,

    output logic                                    res_valid,
    input  logic                                    res_stall,
    output logic signed [firrs_pkg::PCM_W-1:0]      pcm,
    output logic                                    clipped,

    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [firrs_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [firrs_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [firrs_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                    pready
);
    import firrs_pkg::*;

    localparam int ADDR_W = $clog2(MAX_TAPS);

    logic [TAPCNT_W-1:0]    tap_count_reg;
    logic                   reg_sel;
    firrs_cmd_t             ctrl_cmd;
    firrs_status_t          status;
    logic [ADDR_W-1:0]      tap_idx;

    // APB register file: only tap_count; decode ignores the byte lanes
    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_TAP_COUNT);
    assign prdata  = reg_sel ? APB_DATA_W'(tap_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tap_count_reg <= TAP_COUNT_RESET;
        else if (psel && penable && pwrite && pready && reg_sel)
            tap_count_reg <= pwdata[TAPCNT_W-1:0];
    end

    // sequencer: accept, per-tap issue, drain, clamp, scale
    firrs_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (cmd),
        .req_stall (req_stall),
        .tap_count (tap_count_reg),
        .status    (status),
        .ctrl_cmd  (ctrl_cmd),
        .tap_idx   (tap_idx)
    );

    // memories, MAC pipe, clamp/scale and output register
    firrs_dp #(
        .MAX_TAPS (MAX_TAPS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl_cmd   (ctrl_cmd),
        .tap_idx    (tap_idx),
        .status     (status),
        .sample     (sample),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .pcm        (pcm),
        .clipped    (clipped),
        .res_valid  (res_valid),
        .res_stall  (res_stall)
    );

endmodule

`default_nettype wire

### rtl/firrs_ctrl.sv
`default_nettype none

module firrs_ctrl #(
    parameter int MAX_TAPS = 256,
    localparam int ADDR_W = $clog2(MAX_TAPS)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_cmd,
    output logic                            req_stall,
    input  logic [firrs_pkg::TAPCNT_W-1:0]  tap_count,
    input  firrs_pkg::firrs_status_t        status,
    output firrs_pkg::firrs_cmd_t           ctrl_cmd,
    output logic [ADDR_W-1:0]               tap_idx
);
    import firrs_pkg::*;

    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int CMP_W = (CNT_W > TAPCNT_W) ? CNT_W : TAPCNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_CLAMP,
        ST_SCALE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   taps_reg, taps_next;
    logic [CNT_W-1:0]   taps_eff;
    logic               accept;

    // tap count saturates at the ring depth
    assign taps_eff = (CMP_W'(tap_count) > CMP_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS)
                                                            : CNT_W'(tap_count);

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign tap_idx   = k_reg[ADDR_W-1:0];

    always_comb
    begin
        ctrl_cmd.push     = accept && (req_cmd == CMD_PUSH);
        ctrl_cmd.coef_wr  = accept && (req_cmd == CMD_COEF);
        ctrl_cmd.issue    = (state_reg == ST_RUN) && (k_reg != taps_reg);
        ctrl_cmd.clamp    = (state_reg == ST_CLAMP);
        ctrl_cmd.load_out = (state_reg == ST_SCALE) && status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        taps_next  = taps_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctrl_cmd.push)
                begin
                    state_next = ST_RUN;
                    k_next     = '0;
                    taps_next  = taps_eff;
                end
            end
            ST_RUN:
            begin
                if (k_reg == taps_reg)
                    state_next = ST_DRAIN;
                else
                    k_next = k_reg + CNT_W'(1);
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                    state_next = ST_CLAMP;
            end
            ST_CLAMP:
                state_next = ST_SCALE;
            ST_SCALE:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            taps_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            taps_reg  <= taps_next;
        end
    end

    // a tap read is never issued past the tap count
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.issue |-> (k_reg < taps_reg))
        else $error("tap issued past tap count");

    // the sum is only clamped after the multiply-accumulate pipe drained
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLAMP) |-> !status.pipe_busy)
        else $error("clamp while accumulate pipe busy");

endmodule

`default_nettype wire

### rtl/firrs_dp.sv
`default_nettype none

module firrs_dp #(
    parameter int MAX_TAPS = 256,
    localparam int ADDR_W = $clog2(MAX_TAPS)
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  firrs_pkg::firrs_cmd_t                   ctrl_cmd,
    input  logic [ADDR_W-1:0]                       tap_idx,
    output firrs_pkg::firrs_status_t                status,
    input  logic signed [firrs_pkg::SAMPLE_W-1:0]   sample,
    input  logic [firrs_pkg::COEF_IDX_W-1:0]        coef_index,
    input  logic signed [firrs_pkg::COEF_W-1:0]     coef_value,
    output logic signed [firrs_pkg::PCM_W-1:0]      pcm,
    output logic                                    clipped,
    output logic                                    res_valid,
    input  logic                                    res_stall
);
    import firrs_pkg::*;

    localparam int FILL_W = $clog2(MAX_TAPS + 1);
    localparam int IDX_W  = (FILL_W > COEF_IDX_W) ? FILL_W : COEF_IDX_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_TAPS - 1);

    logic signed [COEF_W-1:0]   tap_mem   [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] delay_mem [MAX_TAPS];

    logic [ADDR_W-1:0]          wp_reg;
    logic [ADDR_W-1:0]          rd_ptr_reg;
    logic [FILL_W-1:0]          fill_reg;

    logic signed [COEF_W-1:0]   tap_rd_reg;
    logic signed [SAMPLE_W-1:0] delay_rd_reg;
    logic                       valid1_reg;
    logic                       live1_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       valid2_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W:0]      acc_sum;
    logic signed [ACC_W-1:0]    acc_next;

    logic [MAG_W-1:0]           mag_reg;
    logic                       neg_reg;
    logic                       clip_reg;
    logic                       mag_valid_reg;
    logic [MAG_W+SCALE_SH-1:0]  scaled_full;
    logic [PCM_W-1:0]           scaled;

    logic signed [PCM_W-1:0]    pcm_reg;
    logic                       clipped_reg;
    logic                       res_valid_reg;

    logic [IDX_W-1:0]           idx_ext;
    logic                       coef_ok;

    assign idx_ext = IDX_W'(coef_index);
    assign coef_ok = idx_ext < IDX_W'(MAX_TAPS);

    // memories: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.coef_wr && coef_ok)
            tap_mem[idx_ext[ADDR_W-1:0]] <= coef_value;
        tap_rd_reg <= tap_mem[tap_idx];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.push)
            delay_mem[wp_reg] <= sample;
        delay_rd_reg <= delay_mem[rd_ptr_reg];
    end

    // ring pointers and fill count; slots never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            valid1_reg <= 1'b0;
            live1_reg  <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            if (ctrl_cmd.push)
            begin
                wp_reg     <= (wp_reg == LAST_ADDR) ? '0 : wp_reg + ADDR_W'(1);
                rd_ptr_reg <= wp_reg;
                if (fill_reg != FILL_W'(MAX_TAPS))
                    fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (ctrl_cmd.issue)
            begin
                rd_ptr_reg <= (rd_ptr_reg == '0) ? LAST_ADDR : rd_ptr_reg - ADDR_W'(1);
            end
            valid1_reg <= ctrl_cmd.issue;
            live1_reg  <= ctrl_cmd.issue && (FILL_W'(tap_idx) < fill_reg);
            valid2_reg <= valid1_reg;
        end
    end

    // multiply stage, then saturating accumulate
    always_ff @(posedge clk)
    begin
        if (live1_reg)
            prod_reg <= tap_rd_reg * delay_rd_reg;
        else
            prod_reg <= '0;
    end

    always_comb
    begin
        acc_sum = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(prod_reg);
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
            acc_next = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        else
            acc_next = acc_sum[ACC_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.push)
            acc_reg <= '0;
        else if (valid2_reg)
            acc_reg <= acc_next;
    end

    // clamp to +/-1 and split into sign and magnitude
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.clamp)
        begin
            if (acc_reg > ONE_Q31)
            begin
                mag_reg  <= MAG_W'(ONE_Q31);
                neg_reg  <= 1'b0;
                clip_reg <= 1'b1;
            end
            else if (acc_reg < NEG_ONE_Q31)
            begin
                mag_reg  <= MAG_W'(ONE_Q31);
                neg_reg  <= 1'b1;
                clip_reg <= 1'b1;
            end
            else
            begin
                mag_reg  <= acc_reg[ACC_W-1] ? MAG_W'(-acc_reg) : MAG_W'(acc_reg);
                neg_reg  <= acc_reg[ACC_W-1];
                clip_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mag_valid_reg <= 1'b0;
        else
            mag_valid_reg <= ctrl_cmd.clamp;
    end

    // mag * 32767 / 2^31 as shift-subtract, truncated toward zero
    assign scaled_full = {mag_reg, {SCALE_SH{1'b0}}} - (MAG_W+SCALE_SH)'(mag_reg);
    assign scaled      = scaled_full[MAG_W+SCALE_SH-1 -: PCM_W];

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.load_out)
        begin
            pcm_reg     <= neg_reg ? -scaled : scaled;
            clipped_reg <= clip_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (ctrl_cmd.load_out)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    assign pcm       = pcm_reg;
    assign clipped   = clipped_reg;
    assign res_valid = res_valid_reg;

    assign status.pipe_busy = valid1_reg || valid2_reg;
    assign status.out_free  = !res_valid_reg || !res_stall;

    // a new result never overwrites one still held by the receiver
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.load_out |-> (!res_valid_reg || !res_stall))
        else $error("result overwritten while stalled");

    // clamped magnitude stays within unity
    assert property (@(posedge clk) disable iff (!rst_n)
        mag_valid_reg |-> (mag_reg <= MAG_W'(ONE_Q31)))
        else $error("clamped magnitude above one");

endmodule

`default_nettype wire
